@@ hw/rtl/lidar_point_image_projection_assert.svh @@
// Assertion macros for the lidar point image projection block.
// Included by the checker; no other dependencies.
`ifndef LIDAR_POINT_IMAGE_PROJECTION_ASSERT_SVH
`define LIDAR_POINT_IMAGE_PROJECTION_ASSERT_SVH

// Clocked assertion, masked while reset is held
`define LPIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define LPIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/lpip_pkg.sv @@
// Shared constants and types for the lidar point image projection block.
// No dependencies.
package lpip_pkg;

    localparam int POINT_WIDTH_DEFAULT = 16;
    localparam int LIM_W   = 15;
    localparam int PIX_W   = 12;
    localparam int QUOT_W  = 12;
    localparam int COEF_W  = 26;
    localparam int OFF_W   = 34;
    // sum width is point width plus this
    localparam int SUM_EXTRA = COEF_W + 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd2;

    localparam logic [LIM_W-1:0] LATERAL_LIMIT_RST = 15'd1280;
    localparam logic [PIX_W-1:0] IMAGE_WIDTH_RST   = 12'd640;
    localparam logic [PIX_W-1:0] IMAGE_HEIGHT_RST  = 12'd480;

    // Projection matrix, Q16.16 (z column unused)
    localparam logic signed [COEF_W-1:0] M00 = -26'sd22595182;
    localparam logic signed [COEF_W-1:0] M01 =  26'sd21436876;
    localparam logic signed [COEF_W-1:0] M10 = -26'sd16532043;
    localparam logic signed [COEF_W-1:0] M11 = -26'sd1512313;
    localparam logic signed [COEF_W-1:0] M20 = -26'sd65391;
    localparam logic signed [COEF_W-1:0] M21 = -26'sd4108;

    // Translation column times the homogeneous one (256 in Q8.8)
    localparam logic signed [OFF_W-1:0] OFF_X = 34'sd157138432;
    localparam logic signed [OFF_W-1:0] OFF_Y = 34'sd619334912;
    localparam logic signed [OFF_W-1:0] OFF_Z = 34'sd834304;

    typedef struct packed {
        logic ok;
        logic neg_u;
        logic neg_v;
    } lpip_flags_t;

endpackage

@@ hw/rtl/lpip_front.sv @@
// Window test, matrix products and homogeneous sums (three stages).
// Depends on lpip_pkg.
module lpip_front #(
    parameter int POINT_WIDTH = lpip_pkg::POINT_WIDTH_DEFAULT
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic signed [POINT_WIDTH-1:0]                 point_x,
    input  logic signed [POINT_WIDTH-1:0]                 point_y,
    input  logic [lpip_pkg::LIM_W-1:0]                    lateral_limit,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic                                          out_keep,
    output logic signed [POINT_WIDTH+lpip_pkg::SUM_EXTRA-1:0] out_sx,
    output logic signed [POINT_WIDTH+lpip_pkg::SUM_EXTRA-1:0] out_sy,
    output logic signed [POINT_WIDTH+lpip_pkg::SUM_EXTRA-1:0] out_sz
);
    import lpip_pkg::*;

    localparam int CMP_W  = POINT_WIDTH + LIM_W + 2;
    localparam int PROD_W = POINT_WIDTH + COEF_W;
    localparam int SUM_W  = POINT_WIDTH + SUM_EXTRA;

    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_keep_reg, b_keep_reg, c_keep_reg;
    logic a_rdy, b_rdy, c_rdy;
    logic signed [POINT_WIDTH-1:0] a_x_reg, a_y_reg;
    logic signed [PROD_W-1:0] b_p00_reg, b_p01_reg, b_p10_reg, b_p11_reg, b_p20_reg, b_p21_reg;
    logic signed [SUM_W-1:0] c_sx_reg, c_sy_reg, c_sz_reg;
    logic signed [CMP_W-1:0] y_ext, lim_ext;
    logic keep_next;

    // Stage readiness: a stage moves when empty or when its successor moves
    assign c_rdy    = !c_valid_reg || out_ready;
    assign b_rdy    = !b_valid_reg || c_rdy;
    assign a_rdy    = !a_valid_reg || b_rdy;
    assign in_ready = a_rdy;

    // Window: x negative and y strictly inside the lateral limit
    assign y_ext     = CMP_W'(point_y);
    assign lim_ext   = $signed(CMP_W'(lateral_limit));
    assign keep_next = (y_ext > -lim_ext) && (y_ext < lim_ext) && point_x[POINT_WIDTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_rdy) a_valid_reg <= in_valid;
            if (b_rdy) b_valid_reg <= a_valid_reg;
            if (c_rdy) c_valid_reg <= b_valid_reg;
        end
    end

    // Stage A: capture point and window result
    always_ff @(posedge aclk) begin
        if (a_rdy && in_valid) begin
            a_x_reg    <= point_x;
            a_y_reg    <= point_y;
            a_keep_reg <= keep_next;
        end
    end

    // Stage B: six products
    always_ff @(posedge aclk) begin
        if (b_rdy && a_valid_reg) begin
            b_keep_reg <= a_keep_reg;
            b_p00_reg  <= PROD_W'(M00) * PROD_W'(a_x_reg);
            b_p01_reg  <= PROD_W'(M01) * PROD_W'(a_y_reg);
            b_p10_reg  <= PROD_W'(M10) * PROD_W'(a_x_reg);
            b_p11_reg  <= PROD_W'(M11) * PROD_W'(a_y_reg);
            b_p20_reg  <= PROD_W'(M20) * PROD_W'(a_x_reg);
            b_p21_reg  <= PROD_W'(M21) * PROD_W'(a_y_reg);
        end
    end

    // Stage C: homogeneous sums
    always_ff @(posedge aclk) begin
        if (c_rdy && b_valid_reg) begin
            c_keep_reg <= b_keep_reg;
            c_sx_reg   <= SUM_W'(b_p00_reg) + SUM_W'(b_p01_reg) + SUM_W'(OFF_X);
            c_sy_reg   <= SUM_W'(b_p10_reg) + SUM_W'(b_p11_reg) + SUM_W'(OFF_Y);
            c_sz_reg   <= SUM_W'(b_p20_reg) + SUM_W'(b_p21_reg) + SUM_W'(OFF_Z);
        end
    end

    assign out_valid = c_valid_reg;
    assign out_keep  = c_keep_reg;
    assign out_sx    = c_sx_reg;
    assign out_sy    = c_sy_reg;
    assign out_sz    = c_sz_reg;

endmodule

@@ hw/rtl/lpip_div.sv @@
// Pipelined restoring divider: one quotient bit of u and v per stage.
// Depends on lpip_pkg.
module lpip_div #(
    parameter int POINT_WIDTH = lpip_pkg::POINT_WIDTH_DEFAULT
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic                                          in_keep,
    input  logic signed [POINT_WIDTH+lpip_pkg::SUM_EXTRA-1:0] in_sx,
    input  logic signed [POINT_WIDTH+lpip_pkg::SUM_EXTRA-1:0] in_sy,
    input  logic signed [POINT_WIDTH+lpip_pkg::SUM_EXTRA-1:0] in_sz,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output lpip_pkg::lpip_flags_t                         out_flags,
    output logic [lpip_pkg::QUOT_W-1:0]                   out_qu,
    output logic [lpip_pkg::QUOT_W-1:0]                   out_qv
);
    import lpip_pkg::*;

    localparam int SUM_W = POINT_WIDTH + SUM_EXTRA;
    localparam int EXT_W = SUM_W + QUOT_W;
    localparam int NST   = QUOT_W;

    logic [NST:0]        v_reg;
    logic [NST+1:0]      rdy;
    lpip_flags_t         flg_reg [0:NST];
    logic [SUM_W-1:0]    ru_reg  [0:NST];
    logic [SUM_W-1:0]    rv_reg  [0:NST];
    logic [SUM_W-1:0]    d_reg   [0:NST];
    logic [QUOT_W-1:0]   qu_reg  [0:NST];
    logic [QUOT_W-1:0]   qv_reg  [0:NST];

    logic [SUM_W-1:0]    mag_x, mag_y, mag_z;
    logic [EXT_W-1:0]    lim_z;
    lpip_flags_t         flg_next;

    // Ready chain from the output back to the input
    assign rdy[NST+1] = out_ready;
    for (genvar j = 0; j <= NST; j++) begin : g_rdy
        assign rdy[j] = !v_reg[j] || rdy[j+1];
    end
    assign in_ready = rdy[0];

    // Magnitudes; a quotient of 4096 or more can never land in the image
    assign mag_x = in_sx[SUM_W-1] ? SUM_W'(-in_sx) : SUM_W'(in_sx);
    assign mag_y = in_sy[SUM_W-1] ? SUM_W'(-in_sy) : SUM_W'(in_sy);
    assign mag_z = in_sz[SUM_W-1] ? SUM_W'(-in_sz) : SUM_W'(in_sz);
    assign lim_z = EXT_W'(mag_z) << QUOT_W;

    always_comb begin
        flg_next.ok    = in_keep && (in_sz != '0)
                       && (EXT_W'(mag_x) < lim_z) && (EXT_W'(mag_y) < lim_z);
        flg_next.neg_u = in_sx[SUM_W-1] ^ in_sz[SUM_W-1];
        flg_next.neg_v = in_sy[SUM_W-1] ^ in_sz[SUM_W-1];
    end

    // Prep stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            flg_reg[0] <= flg_next;
            ru_reg[0]  <= mag_x;
            rv_reg[0]  <= mag_y;
            d_reg[0]   <= mag_z;
            qu_reg[0]  <= '0;
            qv_reg[0]  <= '0;
        end
    end

    // Quotient stages, most significant bit first
    for (genvar j = 1; j <= NST; j++) begin : g_stage
        localparam int SH = QUOT_W - j;
        logic [EXT_W-1:0]  dsh, ru_ext, rv_ext;
        logic              take_u, take_v;
        logic [QUOT_W-1:0] bit_mask;

        assign dsh      = EXT_W'(d_reg[j-1]) << SH;
        assign ru_ext   = EXT_W'(ru_reg[j-1]);
        assign rv_ext   = EXT_W'(rv_reg[j-1]);
        assign take_u   = ru_ext >= dsh;
        assign take_v   = rv_ext >= dsh;
        assign bit_mask = QUOT_W'(1) << SH;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[j] && v_reg[j-1]) begin
                flg_reg[j] <= flg_reg[j-1];
                d_reg[j]   <= d_reg[j-1];
                ru_reg[j]  <= take_u ? SUM_W'(ru_ext - dsh) : ru_reg[j-1];
                rv_reg[j]  <= take_v ? SUM_W'(rv_ext - dsh) : rv_reg[j-1];
                qu_reg[j]  <= take_u ? (qu_reg[j-1] | bit_mask) : qu_reg[j-1];
                qv_reg[j]  <= take_v ? (qv_reg[j-1] | bit_mask) : qv_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[NST];
    assign out_flags = flg_reg[NST];
    assign out_qu    = qu_reg[NST];
    assign out_qv    = qv_reg[NST];

endmodule

@@ hw/rtl/lidar_point_image_projection.sv @@
// Top level of the lidar point image projection block.
// Depends on lpip_pkg, lpip_front and lpip_div.
//
// Projects one lidar ground point (x, y, Q8.8 metres) per cycle through a fixed
// 3x4 camera matrix and reports whether it lands in the image, with pixel u and v
// (zero when it does not). Points are windowed by x < 0 and |y| < lateral_limit.
// Throughput is one transaction per clock when the output does not stall; from input
// accept to result valid a point passes three stages for window, products and sums,
// one prep and twelve one-bit restoring divider stages, and the output register.
// Back-pressure ripples stage by stage, so bubbles are squeezed out while the output
// stalls. Configuration writes take effect at once and are meant for idle periods.
module lidar_point_image_projection #(
    parameter int POINT_WIDTH = lpip_pkg::POINT_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lpip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpip_pkg::LIM_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [POINT_WIDTH-1:0]     s_point_x,
    input  logic signed [POINT_WIDTH-1:0]     s_point_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_in_frame,
    output logic [lpip_pkg::PIX_W-1:0]        m_pixel_u,
    output logic [lpip_pkg::PIX_W-1:0]        m_pixel_v
);
    import lpip_pkg::*;

    localparam int SUM_W = POINT_WIDTH + SUM_EXTRA;

    logic [LIM_W-1:0] lateral_limit_reg;
    logic [PIX_W-1:0] image_width_reg, image_height_reg;

    logic                    f_valid, f_ready, f_keep;
    logic signed [SUM_W-1:0] f_sx, f_sy, f_sz;
    logic                    d_valid, d_ready;
    lpip_flags_t             d_flags;
    logic [QUOT_W-1:0]       d_qu, d_qv;

    logic             m_valid_reg, m_in_frame_reg;
    logic [PIX_W-1:0] m_pixel_u_reg, m_pixel_v_reg;
    logic             in_frame_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lateral_limit_reg <= LATERAL_LIMIT_RST;
            image_width_reg   <= IMAGE_WIDTH_RST;
            image_height_reg  <= IMAGE_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LATERAL_LIMIT: lateral_limit_reg <= cfg_wdata;
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata[PIX_W-1:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_wdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    lpip_front #(.POINT_WIDTH(POINT_WIDTH)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .point_x       (s_point_x),
        .point_y       (s_point_y),
        .lateral_limit (lateral_limit_reg),
        .out_valid     (f_valid),
        .out_ready     (f_ready),
        .out_keep      (f_keep),
        .out_sx        (f_sx),
        .out_sy        (f_sy),
        .out_sz        (f_sz)
    );

    lpip_div #(.POINT_WIDTH(POINT_WIDTH)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_keep   (f_keep),
        .in_sx     (f_sx),
        .in_sy     (f_sy),
        .in_sz     (f_sz),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_flags (d_flags),
        .out_qu    (d_qu),
        .out_qv    (d_qv)
    );

    // Final range check; a negative quotient that truncates to zero still counts
    assign in_frame_next = d_flags.ok
                         && (!d_flags.neg_u || (d_qu == '0))
                         && (!d_flags.neg_v || (d_qv == '0))
                         && (d_qu < image_width_reg)
                         && (d_qv < image_height_reg);

    assign d_ready = !m_valid_reg || m_ready;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (d_ready) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && d_valid) begin
            m_in_frame_reg <= in_frame_next;
            m_pixel_u_reg  <= in_frame_next ? d_qu : '0;
            m_pixel_v_reg  <= in_frame_next ? d_qv : '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_in_frame = m_in_frame_reg;
    assign m_pixel_u  = m_pixel_u_reg;
    assign m_pixel_v  = m_pixel_v_reg;

endmodule

@@ hw/rtl/lpip_checker.sv @@
// Port-level checker for the lidar point image projection block, with its bind.
// Depends on lpip_pkg and lidar_point_image_projection_assert.svh.
`include "lidar_point_image_projection_assert.svh"

module lpip_assert_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_in_frame,
    input logic [lpip_pkg::PIX_W-1:0] m_pixel_u,
    input logic [lpip_pkg::PIX_W-1:0] m_pixel_v
);
    logic [2*lpip_pkg::PIX_W-1:0] m_pixels;
    logic [2*lpip_pkg::PIX_W:0]   m_payload;

    assign m_pixels  = {m_pixel_u, m_pixel_v};
    assign m_payload = {m_in_frame, m_pixels};

    // Reset empties the pipeline
    `LPIP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    // A rejected point reports a zero pixel
    `LPIP_ASSERT(a_zero_pixel, m_valid && !m_in_frame |-> m_pixels == '0, "nonzero pixel")

    // A taking sink frees the whole pipe, so the input is free too
    `LPIP_ASSERT(a_ready_chain, m_ready |-> s_ready, "input stalled while output drains")

    // A stalled result holds
    `LPIP_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_payload), "result changed")

endmodule

bind lidar_point_image_projection lpip_assert_checker u_lpip_assert_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_in_frame (m_in_frame),
    .m_pixel_u  (m_pixel_u),
    .m_pixel_v  (m_pixel_v)
);

@@ dv/lpip_checker.sv @@
// Scoreboard for the lidar point image projection block: predicts each result
// from the accepted point and the register settings, compares in order.
// Depends on lpip_pkg.
module lpip_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lpip_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpip_pkg::LIM_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic signed [15:0]             s_point_x,
    input  logic signed [15:0]             s_point_y,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_in_frame,
    input  logic [lpip_pkg::PIX_W-1:0]     m_pixel_u,
    input  logic [lpip_pkg::PIX_W-1:0]     m_pixel_v,
    output int                             fail_count,
    output int                             pending_count
);
    import lpip_pkg::*;

    typedef struct packed {
        logic             in_frame;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
    } pixel_t;

    pixel_t                 pixel_queue[$];
    logic [LIM_W-1:0]       lim_q;
    logic [PIX_W-1:0]       width_q;
    logic [PIX_W-1:0]       height_q;

    // Project one point through the camera matrix
    function automatic pixel_t project_point(logic signed [15:0] px, logic signed [15:0] py);
        longint x, y, lim, sx, sy, sz, u, v;
        pixel_t r;
        x = px;
        y = py;
        lim = lim_q;
        r = '0;
        if (!(y > -lim && y < lim && x < 0))
            return r;
        sx = -64'sd22595182 * x + 64'sd21436876 * y + 64'sd613822 * 256;
        sy = -64'sd16532043 * x - 64'sd1512313 * y + 64'sd2419277 * 256;
        sz = -64'sd65391 * x - 64'sd4108 * y + 64'sd3259 * 256;
        if (sz == 0)
            return r;
        u = sx / sz;
        v = sy / sz;
        if (u < 0 || v < 0 || u >= longint'(width_q) || v >= longint'(height_q))
            return r;
        r.in_frame = 1'b1;
        r.u = u[PIX_W-1:0];
        r.v = v[PIX_W-1:0];
        return r;
    endfunction

    // Track registers, queue predictions, compare results
    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            lim_q <= LATERAL_LIMIT_RST;
            width_q <= IMAGE_WIDTH_RST;
            height_q <= IMAGE_HEIGHT_RST;
            pixel_queue.delete();
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LATERAL_LIMIT: lim_q <= cfg_wdata;
                    CFG_IMAGE_WIDTH:   width_q <= cfg_wdata[PIX_W-1:0];
                    CFG_IMAGE_HEIGHT:  height_q <= cfg_wdata[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pixel_queue.insert(pixel_queue.size(), project_point(s_point_x, s_point_y));
            if (m_valid && m_ready) begin
                if (pixel_queue.size() == 0) begin
                    $error("unexpected result transaction");
                    fail_count <= fail_count + 1;
                end else begin
                    want = pixel_queue.pop_front();
                    if (want.in_frame !== m_in_frame || want.u !== m_pixel_u ||
                        want.v !== m_pixel_v) begin
                        fail_count <= fail_count + 1;
                        if (want.in_frame !== m_in_frame)
                            $error("in_frame: expected %0d got %0d", want.in_frame, m_in_frame);
                        if (want.u !== m_pixel_u)
                            $error("pixel_u: expected %0d got %0d", want.u, m_pixel_u);
                        if (want.v !== m_pixel_v)
                            $error("pixel_v: expected %0d got %0d", want.v, m_pixel_v);
                    end
                end
            end
            pending_count <= pixel_queue.size();
        end
    end
endmodule

@@ dv/lidar_point_image_projection_test.sv @@
// Testbench top for the lidar point image projection block: drives points and
// register writes with random gaps and stalls, and reports the verdict.
// Depends on lpip_pkg, lpip_checker and the block itself.
module lidar_point_image_projection_test;
    import lpip_pkg::*;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [LIM_W-1:0]         cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [15:0]       s_point_x = '0;
    logic signed [15:0]       s_point_y = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_in_frame;
    logic [PIX_W-1:0]         m_pixel_u;
    logic [PIX_W-1:0]         m_pixel_v;
    int                       fail_count;
    int                       pending_count;
    int                       idle_cycles = 0;

    localparam int LATENCY = 17;
    localparam int IDLE_LIMIT = 2000;
    // Index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    lidar_point_image_projection i_dut (.*);

    lpip_checker i_checker (.*);

    // Receiver stall pattern: phases of free flow, light and heavy back-pressure
    always @(negedge aclk) begin
        int mode;
        mode = ($urandom_range(0, 63) == 0) ? $urandom_range(0, 2) : mode;
        case (mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    int burst_left = 0;

    // Present one point and hold it until accepted; drop valid only for a gap
    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop sending and let the pipeline empty before touching registers
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // Mostly points behind the sensor in and around the window, some anywhere
    task automatic random_points(int count);
        logic signed [15:0] x, y;
        repeat (count) begin
            if ($urandom_range(0, 3) != 0) begin
                x = -$signed({1'b0, 15'($urandom_range(1, 4000))});
                y = $signed(16'($urandom_range(0, 2800))) - 16'sd1400;
            end else begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            send_point(x, y);
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: field extremes, window edges, small negative x
        send_point(16'sh8000, 16'sh8000);
        send_point(16'sh7fff, 16'sh7fff);
        send_point(16'shffff, 16'sh0000);
        send_point(16'sh0000, 16'sh0000);
        send_point(-16'sd256, 16'sd1279);
        send_point(-16'sd256, 16'sd1280);
        send_point(-16'sd256, -16'sd1279);
        send_point(-16'sd256, -16'sd1280);
        send_point(-16'sd512, 16'sd0);
        send_point(-16'sd1024, 16'sd300);
        send_point(-16'sd2000, -16'sd500);
        send_point(16'sh8000, 16'sd0);
        send_point(-16'sd13, 16'sd0);
        send_point(-16'sd12, 16'sd0);
        send_point(-16'sd5555, 16'sd777);
        random_points(400);
        drain();

        // Widest window, largest image
        write_reg(CFG_LATERAL_LIMIT, 15'h7fff);
        write_reg(CFG_IMAGE_WIDTH, 15'd4095);
        write_reg(CFG_IMAGE_HEIGHT, 15'd4095);
        send_point(16'sh8000, 16'sh8001);
        send_point(16'shffff, 16'sh7fff);
        random_points(400);
        drain();

        // Closed window, tiny image, unknown index
        write_reg(CFG_LATERAL_LIMIT, 15'd0);
        write_reg(CFG_IMAGE_WIDTH, 15'd1);
        write_reg(CFG_IMAGE_HEIGHT, 15'd1);
        write_reg(CFG_UNUSED_IDX, 15'h7fff);
        random_points(150);
        drain();

        // Zero image size, then random settings
        write_reg(CFG_LATERAL_LIMIT, 15'd2000);
        write_reg(CFG_IMAGE_WIDTH, 15'h7000);
        write_reg(CFG_IMAGE_HEIGHT, 15'd0);
        random_points(150);
        drain();
        write_reg(CFG_LATERAL_LIMIT, 15'($urandom));
        write_reg(CFG_IMAGE_WIDTH, 15'($urandom_range(1, 4095)));
        write_reg(CFG_IMAGE_HEIGHT, 15'($urandom_range(1, 4095)));
        random_points(500);

        drain();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
